// ----- hdl/mrwt_pkg.sv -----
// Shared types and constants for the Miller-Rabin witness test block.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mrwt_pkg;

   // Beat field widths as seen on the ports.
   localparam int CAND_WIDTH      = 63;
   localparam int WIT_WIDTH       = 63;
   localparam int REQ_TDATA_WIDTH = 128;
   localparam int RSP_TDATA_WIDTH = 8;

   // Operand selection for the shared modular multiplier.
   typedef enum logic [1:0] {
      MUL_REDUCE  = 2'd0,   // 1 * witness, which reduces the witness mod n
      MUL_POW_ACC = 2'd1,   // accumulator * running square
      MUL_POW_SQ  = 2'd2,   // running square * running square
      MUL_SQUARE  = 2'd3    // accumulator * accumulator
   } mul_op_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;       // capture a new candidate and witness
      logic       shift_e;    // shift the exponent right by one
      logic       inc_t;      // count one more factor of two
      logic       dec_t;      // one squaring step done
      logic       mul_start;  // launch the modular multiplier
      mul_op_type mul_op;
      logic       wr_sq;      // multiplier result into the running square
      logic       wr_acc;     // multiplier result into the accumulator
      logic       acc_one;    // set the accumulator to one
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic n_is_two;
      logic n_trivial;    // candidate below two, or even
      logic e_lsb;
      logic e_zero;
      logic t_zero;
      logic mul_done;
      logic res_is_one;
      logic acc_is_one;
      logic acc_is_nm1;
   } sts_type;

endpackage

`default_nettype wire

// ----- hdl/miller_rabin_witness_test.sv -----
// Top level of the Miller-Rabin witness test: one round per request beat.
// Depends on mrwt_pkg, mrwt_ctrl, mrwt_dpath (and mrwt_mulmod below it).
//
//   Channel  Dir  Beat content
//   req_*    in   tdata[62:0] candidate, tdata[125:63] witness, tdata[127:126] zero
//   rsp_*    out  tdata[0] probably_prime, tdata[7:1] zero
//
// A round is one witness reduction, up to two products per exponent bit of u and up
// to t squarings, where n - 1 = u * 2^t, all run in turn on the single shift-and-add
// modular multiplier. Since t + bitlen(u) is at most NUM_BITS, a full-width
// candidate with t = 1 is the slowest case. Special candidates (two, below two,
// even) skip the multiplier and go from classification straight to delivery. Reset
// is synchronous and active high and clears the controller and the result register.
// A finished result waits in the result register while the next request beat is
// accepted; a stalled result only holds the controller at its end.
`timescale 1ns / 1ps
`default_nettype none

module miller_rabin_witness_test
   import mrwt_pkg::*;
#(
   parameter int NUM_BITS = 63
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0 up: candidate (63), witness (63), zero pad (2).
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // Fields from bit 0 up: probably_prime (1), zero pad (7).
   output logic [RSP_TDATA_WIDTH-1:0]      rsp_tdata
);

   cmd_type               cmd;
   sts_type               sts;
   logic                  rsp_prime;
   logic [CAND_WIDTH-1:0] candidate;
   logic [WIT_WIDTH-1:0]  witness;

   // Unpack the request beat; only the low NUM_BITS bits of each field are used.
   assign candidate = req_tdata[CAND_WIDTH-1:0];
   assign witness   = req_tdata[CAND_WIDTH+WIT_WIDTH-1:CAND_WIDTH];

   // The controller owns both handshakes and the result register.
   mrwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_prime  (rsp_prime),
      .cmd        (cmd),
      .sts        (sts)
   );

   // The datapath holds the operands and the shared modular multiplier.
   mrwt_dpath #(
      .NUM_BITS (NUM_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .candidate (candidate),
      .witness   (witness),
      .cmd       (cmd),
      .sts       (sts)
   );

   assign rsp_tdata = {{(RSP_TDATA_WIDTH-1){1'b0}}, rsp_prime};

endmodule

`default_nettype wire

// ----- hdl/mrwt_mulmod.sv -----
// Shift-and-add modular multiplier: one multiplier bit per cycle.
// Depends on nothing; instantiated by the datapath.
`timescale 1ns / 1ps
`default_nettype none

module mrwt_mulmod #(
   parameter int NUM_BITS = 63
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] x,       // must be below m
   input  wire logic [NUM_BITS-1:0] y,
   input  wire logic [NUM_BITS-1:0] m,
   output logic                     done,
   output logic [NUM_BITS-1:0]      result
);

   logic                busy_ff;
   logic                done_ff;
   logic [NUM_BITS-1:0] acc_ff, acc_in;
   logic [NUM_BITS-1:0] addend_ff, addend_in;
   logic [NUM_BITS-1:0] y_ff;
   logic [NUM_BITS:0]   sum;
   logic [NUM_BITS:0]   dbl;
   logic [NUM_BITS:0]   m_ext;

   // Both corrections work independently, so they sit side by side.
   always_comb begin
      m_ext = {1'b0, m};
      sum   = {1'b0, acc_ff} + {1'b0, addend_ff};
      dbl   = {addend_ff, 1'b0};
      if (sum >= m_ext) begin
         acc_in = NUM_BITS'(sum - m_ext);
      end else begin
         acc_in = sum[NUM_BITS-1:0];
      end
      if (dbl >= m_ext) begin
         addend_in = NUM_BITS'(dbl - m_ext);
      end else begin
         addend_in = dbl[NUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (y_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         addend_ff <= x;
         y_ff      <= y;
      end else if (busy_ff && (y_ff != '0)) begin
         if (y_ff[0]) begin
            acc_ff <= acc_in;
         end
         addend_ff <= addend_in;
         y_ff      <= y_ff >> 1;
      end
   end

   assign done   = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

// ----- hdl/mrwt_dpath.sv -----
// Datapath of the witness test: operand registers, exponent and
// two-count, and the shared modular multiplier. Depends on mrwt_pkg, mrwt_mulmod.
`timescale 1ns / 1ps
`default_nettype none

module mrwt_dpath
   import mrwt_pkg::*;
#(
   parameter int NUM_BITS = 63
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [CAND_WIDTH-1:0] candidate,
   input  wire logic [WIT_WIDTH-1:0]  witness,
   input  wire cmd_type               cmd,
   output sts_type                    sts
);

   localparam int TW = $clog2(NUM_BITS);

   logic [NUM_BITS-1:0] n_ff;
   logic [NUM_BITS-1:0] nm1_ff;
   logic [NUM_BITS-1:0] w_ff;
   logic [NUM_BITS-1:0] sq_ff;
   logic [NUM_BITS-1:0] acc_ff;
   logic [NUM_BITS-1:0] e_ff;
   logic [TW-1:0]       t_ff;
   logic [NUM_BITS-1:0] cand_in;
   logic [NUM_BITS-1:0] mul_x;
   logic [NUM_BITS-1:0] mul_y;
   logic [NUM_BITS-1:0] mul_res;
   logic                mul_done;

   assign cand_in = candidate[NUM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff   <= cand_in;
         nm1_ff <= cand_in - NUM_BITS'(1);
         e_ff   <= cand_in - NUM_BITS'(1);
         w_ff   <= witness[NUM_BITS-1:0];
         t_ff   <= '0;
      end else begin
         if (cmd.shift_e) begin
            e_ff <= e_ff >> 1;
         end
         if (cmd.inc_t) begin
            t_ff <= t_ff + TW'(1);
         end else if (cmd.dec_t) begin
            t_ff <= t_ff - TW'(1);
         end
      end
      if (cmd.wr_sq) begin
         sq_ff <= mul_res;
      end
      if (cmd.acc_one) begin
         acc_ff <= NUM_BITS'(1);
      end else if (cmd.wr_acc) begin
         acc_ff <= mul_res;
      end
   end

   always_comb begin
      case (cmd.mul_op)
         MUL_REDUCE: begin
            mul_x = NUM_BITS'(1);
            mul_y = w_ff;
         end
         MUL_POW_ACC: begin
            mul_x = acc_ff;
            mul_y = sq_ff;
         end
         MUL_POW_SQ: begin
            mul_x = sq_ff;
            mul_y = sq_ff;
         end
         MUL_SQUARE: begin
            mul_x = acc_ff;
            mul_y = acc_ff;
         end
         default: begin
            mul_x = acc_ff;
            mul_y = acc_ff;
         end
      endcase
   end

   mrwt_mulmod #(
      .NUM_BITS (NUM_BITS)
   ) u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.mul_start),
      .x      (mul_x),
      .y      (mul_y),
      .m      (n_ff),
      .done   (mul_done),
      .result (mul_res)
   );

   always_comb begin
      sts.n_is_two   = (n_ff == NUM_BITS'(2));
      sts.n_trivial  = (n_ff[NUM_BITS-1:1] == '0) || !n_ff[0];
      sts.e_lsb      = e_ff[0];
      sts.e_zero     = (e_ff == '0);
      sts.t_zero     = (t_ff == '0);
      sts.mul_done   = mul_done;
      sts.res_is_one = (mul_res == NUM_BITS'(1));
      sts.acc_is_one = (acc_ff == NUM_BITS'(1));
      sts.acc_is_nm1 = (acc_ff == nm1_ff);
   end

endmodule

`default_nettype wire

// ----- hdl/mrwt_ctrl.sv -----
// Controller of the witness test: sequences the special cases, the split of
// n-1, the exponentiation and the squaring chain. Depends on mrwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrwt_ctrl
   import mrwt_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic         rsp_prime,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_SPLIT,
      ST_REDUCE,
      ST_REDUCE_WAIT,
      ST_POW,
      ST_POW_MUL_WAIT,
      ST_POW_SQ,
      ST_POW_SQ_WAIT,
      ST_SQUARE,
      ST_SQUARE_WAIT,
      ST_DELIVER
   } state_type;

   state_type state_ff;
   logic      verdict_ff;
   logic      rsp_valid_ff;
   logic      rsp_prime_ff;
   logic      nontrivial_root;

   assign req_tready      = (state_ff == ST_IDLE);
   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_prime       = rsp_prime_ff;
   assign nontrivial_root = sts.res_is_one && !sts.acc_is_one && !sts.acc_is_nm1;

   always_comb begin
      cmd = '0;
      cmd.mul_op = MUL_SQUARE;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = req_tvalid;
         end
         ST_SPLIT: begin
            cmd.shift_e = !sts.e_lsb;
            cmd.inc_t   = !sts.e_lsb;
         end
         ST_REDUCE: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_REDUCE;
         end
         ST_REDUCE_WAIT: begin
            cmd.mul_op  = MUL_REDUCE;
            cmd.wr_sq   = sts.mul_done;
            cmd.acc_one = sts.mul_done;
         end
         ST_POW: begin
            cmd.mul_start = !sts.e_zero && sts.e_lsb;
            cmd.mul_op    = MUL_POW_ACC;
         end
         ST_POW_MUL_WAIT: begin
            cmd.mul_op = MUL_POW_ACC;
            cmd.wr_acc = sts.mul_done;
         end
         ST_POW_SQ: begin
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_POW_SQ;
         end
         ST_POW_SQ_WAIT: begin
            cmd.mul_op  = MUL_POW_SQ;
            cmd.wr_sq   = sts.mul_done;
            cmd.shift_e = sts.mul_done;
         end
         ST_SQUARE: begin
            cmd.mul_start = !sts.t_zero;
         end
         ST_SQUARE_WAIT: begin
            cmd.wr_acc = sts.mul_done && !nontrivial_root;
            cmd.dec_t  = sts.mul_done && !nontrivial_root;
         end
         default: begin
            cmd = '0;
            cmd.mul_op = MUL_SQUARE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         verdict_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_prime_ff <= 1'b0;
      end else begin
         // A taken result is retired unless a new one replaces it this cycle.
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_DELIVER)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_CLASSIFY;
               end
            end
            ST_CLASSIFY: begin
               if (sts.n_is_two) begin
                  verdict_ff <= 1'b1;
                  state_ff   <= ST_DELIVER;
               end else if (sts.n_trivial) begin
                  verdict_ff <= 1'b0;
                  state_ff   <= ST_DELIVER;
               end else begin
                  state_ff <= ST_SPLIT;
               end
            end
            ST_SPLIT: begin
               if (sts.e_lsb) begin
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               state_ff <= ST_REDUCE_WAIT;
            end
            ST_REDUCE_WAIT: begin
               if (sts.mul_done) begin
                  state_ff <= ST_POW;
               end
            end
            ST_POW: begin
               if (sts.e_zero) begin
                  state_ff <= ST_SQUARE;
               end else if (sts.e_lsb) begin
                  state_ff <= ST_POW_MUL_WAIT;
               end else begin
                  state_ff <= ST_POW_SQ;
               end
            end
            ST_POW_MUL_WAIT: begin
               if (sts.mul_done) begin
                  state_ff <= ST_POW_SQ;
               end
            end
            ST_POW_SQ: begin
               state_ff <= ST_POW_SQ_WAIT;
            end
            ST_POW_SQ_WAIT: begin
               if (sts.mul_done) begin
                  state_ff <= ST_POW;
               end
            end
            ST_SQUARE: begin
               if (sts.t_zero) begin
                  verdict_ff <= sts.acc_is_one;
                  state_ff   <= ST_DELIVER;
               end else begin
                  state_ff <= ST_SQUARE_WAIT;
               end
            end
            ST_SQUARE_WAIT: begin
               if (sts.mul_done) begin
                  if (nontrivial_root) begin
                     verdict_ff <= 1'b0;
                     state_ff   <= ST_DELIVER;
                  end else begin
                     state_ff <= ST_SQUARE;
                  end
               end
            end
            ST_DELIVER: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_prime_ff <= verdict_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire
